@@ sv/ltfm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ltfm_pkg: shared widths, codes, reset values and structs for the tween block
// no dependencies; imported by every other file of the block except ltfm_if

package ltfm_pkg;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int PERIOD_W   = 24;
  localparam int TIMER_W    = 25;
  localparam int STEP_W     = 16;
  localparam int PIX_W      = 16;
  localparam int POS_W      = 32;
  localparam int ALPHA_W    = 8;
  localparam int MODE_W     = 6;

  // shared divider: 48-bit dividend, two quotient bits per cycle
  localparam int DIV_NUM_W  = 48;
  localparam int DIV_Q_W    = 32;
  localparam int DIV_STEPS  = DIV_NUM_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // shared multiplier: 16-bit by 25-bit
  localparam int MUL_A_W    = 16;
  localparam int MUL_P_W    = MUL_A_W + TIMER_W;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_MODE_CONTROL = 3'd0;
  localparam logic [2:0] REG_FADE_PERIOD  = 3'd1;
  localparam logic [2:0] REG_ALPHA_START  = 3'd2;
  localparam logic [2:0] REG_ALPHA_END    = 3'd3;
  localparam logic [2:0] REG_MOVE_PERIOD  = 3'd4;
  localparam logic [2:0] REG_START_POINT  = 3'd5;
  localparam logic [2:0] REG_END_POINT    = 3'd6;

  // reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd1000000;
  localparam logic [ALPHA_W-1:0]  ALPHA_END_RST = 8'd255;

  // input item kinds
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_RESTART = 2'd1;
  localparam logic [1:0] KIND_SETPOS  = 2'd2;

  // engine modes
  localparam logic [1:0] MODE_ONCE     = 2'd0;
  localparam logic [1:0] MODE_LOOP     = 2'd1;
  localparam logic [1:0] MODE_PINGPONG = 2'd2;
  localparam logic [1:0] MODE_IDLE     = 2'd3;

  localparam int FADE_EN_BIT = 0;
  localparam int MOVE_EN_BIT = 3;

  typedef struct packed {
    logic [MODE_W-1:0]   mode_control;
    logic [PERIOD_W-1:0] fade_period;
    logic [ALPHA_W-1:0]  alpha_start;
    logic [ALPHA_W-1:0]  alpha_end;
    logic [PERIOD_W-1:0] move_period;
    logic [POS_W-1:0]    start_point;
    logic [POS_W-1:0]    end_point;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [PERIOD_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ sv/ltfm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ltfm_cmd_if / ltfm_res_if: valid-ready channels for input items and results
// no dependencies

interface ltfm_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [15:0]        step_time;
  logic signed [15:0] new_x;
  logic signed [15:0] new_y;

  modport source (output valid, kind, step_time, new_x, new_y, input ready);
  modport sink   (input valid, kind, step_time, new_x, new_y, output ready);
endinterface

interface ltfm_res_if;
  logic               valid;
  logic               ready;
  logic [7:0]         alpha;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               fade_running;
  logic               move_running;

  modport source (output valid, alpha, pos_x, pos_y, fade_running, move_running,
                  input ready);
  modport sink   (input valid, alpha, pos_x, pos_y, fade_running, move_running,
                  output ready);
endinterface

`default_nettype wire

@@ sv/linear_tween_fade_and_move.sv @@
`timescale 1ns / 1ps
`default_nettype none
// linear_tween_fade_and_move: fade and move tween engines with sequencer,
// shared multiplier and output register; depends on ltfm_pkg, ltfm_if,
// ltfm_cfg_regs and ltfm_div
//
//   channel | kind        | payload
//   --------+-------------+---------------------------------------------------
//   cmd     | valid/ready | kind, step_time, new_x, new_y
//   res     | valid/ready | alpha, pos_x, pos_y, fade_running, move_running
//   apb     | psel/penable| paddr, pwdata, prdata, pready (always high)
//
// one cmd transaction at a time; cmd.ready is high only in the idle state.
// restart, set position and unused kinds go through the done state to the result register.
// a tick runs up to three divisions on the
// shared divider (fade alpha, move x, move y) plus the sequencing steps;
// inactive or idle-mode engines skip their divisions.
// the result register frees the input side: a new transaction is taken while
// an earlier result still waits on res.ready; the sequencer stalls only to load.
// rst is synchronous; it restores the model reset state and the registers.

module linear_tween_fade_and_move
  import ltfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  ltfm_cmd_if.sink              cmd,
  ltfm_res_if.source            res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_FADE = 10'b00_0000_0010,
    S_FMUL = 10'b00_0000_0100,
    S_FDIV = 10'b00_0000_1000,
    S_MOVE = 10'b00_0001_0000,
    S_XMUL = 10'b00_0010_0000,
    S_XDIV = 10'b00_0100_0000,
    S_YMUL = 10'b00_1000_0000,
    S_YDIV = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } seq_state_t;

  function automatic logic [POS_W-1:0] pixel_to_q(input logic [PIX_W-1:0] v);
    return {v, {(POS_W - PIX_W){1'b0}}};
  endfunction

  cfg_t       cfg;
  div_req_t   div_req;
  div_rsp_t   div_rsp;
  seq_state_t state;

  // tween state
  logic               fade_active, fade_rising, move_active, move_forward;
  logic [TIMER_W-1:0] fade_timer, move_timer;
  logic [ALPHA_W-1:0] alpha_level;
  logic [POS_W-1:0]   position_x, position_y;

  // per-tick operands latched for the multiplier
  logic [STEP_W-1:0]  step_r;
  logic [TIMER_W-1:0] fade_t_op;
  logic [ALPHA_W-1:0] fade_mag;
  logic               fade_neg;
  logic [PIX_W-1:0]   mag_x, mag_y;
  logic               neg_x, neg_y;

  // result register
  logic               res_valid;
  logic [ALPHA_W-1:0] res_alpha;
  logic [PIX_W-1:0]   res_pos_x, res_pos_y;
  logic               res_fade, res_move;

  ltfm_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ltfm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // handshake
  logic cmd_fire, out_free;
  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_free  = !res_valid || res.ready;

  // live configuration views; a zero period counts as one
  logic [PERIOD_W-1:0] fade_p, move_p;
  logic [1:0]          fade_mode, move_mode;
  assign fade_p    = (cfg.fade_period == '0) ? PERIOD_W'(1) : cfg.fade_period;
  assign move_p    = (cfg.move_period == '0) ? PERIOD_W'(1) : cfg.move_period;
  assign fade_mode = cfg.mode_control[2:1];
  assign move_mode = cfg.mode_control[5:4];

  // timer checks and advance
  logic               fade_expire, fade_stay, move_expire, move_stay;
  logic [TIMER_W-1:0] fade_adv, move_adv;
  assign fade_expire = fade_timer > {1'b0, fade_p};
  assign fade_stay   = !fade_expire;
  assign fade_adv    = fade_timer + TIMER_W'(step_r);
  assign move_expire = move_timer > {1'b0, move_p};
  assign move_stay   = !move_expire;
  assign move_adv    = move_timer + TIMER_W'(step_r);

  // alpha span and per-axis spans in whole pixels
  logic [ALPHA_W:0]   fade_d, fade_d_n;
  logic [PIX_W:0]     dx, dy, dx_n, dy_n;
  assign fade_d   = {1'b0, cfg.alpha_end} - {1'b0, cfg.alpha_start};
  assign fade_d_n = (ALPHA_W + 1)'(0) - fade_d;
  assign dx   = {cfg.end_point[PIX_W-1], cfg.end_point[PIX_W-1:0]}
              - {cfg.start_point[PIX_W-1], cfg.start_point[PIX_W-1:0]};
  assign dy   = {cfg.end_point[POS_W-1], cfg.end_point[POS_W-1:PIX_W]}
              - {cfg.start_point[POS_W-1], cfg.start_point[POS_W-1:PIX_W]};
  assign dx_n = (PIX_W + 1)'(0) - dx;
  assign dy_n = (PIX_W + 1)'(0) - dy;

  // shared multiplier: |d_alpha| * timer, or |d_axis| * step_time
  logic [MUL_A_W-1:0] mul_a;
  logic [TIMER_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  always_comb begin
    case (state)
      S_FMUL:  mul_a = MUL_A_W'(fade_mag);
      S_XMUL:  mul_a = mag_x;
      default: mul_a = mag_y;
    endcase
    mul_b = (state == S_FMUL) ? fade_t_op : TIMER_W'(step_r);
    mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  // divider request: fade dividend as is, move dividend scaled to q16.16
  always_comb begin
    div_req.start = (state == S_FMUL) || (state == S_XMUL) || (state == S_YMUL);
    div_req.den   = (state == S_FMUL) ? fade_p : move_p;
    if (state == S_FMUL) begin
      div_req.num = DIV_NUM_W'(mul_p);
    end else begin
      div_req.num = {mul_p[POS_W-1:0], {(DIV_NUM_W - POS_W){1'b0}}};
    end
  end

  // alpha from the quotient; rising rounds toward start, falling toward end
  logic [ALPHA_W-1:0] q8, alpha_c;
  logic               fade_up;
  assign q8      = div_rsp.quot[ALPHA_W-1:0];
  assign fade_up = (fade_mode != MODE_PINGPONG) || fade_rising;
  always_comb begin
    if (fade_up) begin
      alpha_c = fade_neg ? cfg.alpha_start - q8 : cfg.alpha_start + q8;
    end else begin
      alpha_c = fade_neg ? cfg.alpha_end + q8 : cfg.alpha_end - q8;
    end
  end

  // move step direction: span sign flipped on the ping-pong return leg
  logic move_back, x_sub, y_sub;
  assign move_back = (move_mode == MODE_PINGPONG) && !move_forward;
  assign x_sub     = neg_x ^ move_back;
  assign y_sub     = neg_y ^ move_back;

  // sequencer and tween state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fade_active  <= 1'b0;
      fade_timer   <= '0;
      fade_rising  <= 1'b1;
      alpha_level  <= ALPHA_END_RST;
      move_active  <= 1'b0;
      move_timer   <= '0;
      move_forward <= 1'b1;
      position_x   <= '0;
      position_y   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            case (cmd.kind)
              KIND_TICK: state <= S_FADE;
              KIND_RESTART: begin
                // arm enabled engines; direction and position are kept
                if (cfg.mode_control[FADE_EN_BIT]) begin
                  fade_active <= 1'b1;
                  fade_timer  <= '0;
                  alpha_level <= cfg.alpha_start;
                end
                if (cfg.mode_control[MOVE_EN_BIT]) begin
                  move_active <= 1'b1;
                  move_timer  <= '0;
                end
                state <= S_DONE;
              end
              KIND_SETPOS: begin
                position_x <= pixel_to_q(cmd.new_x);
                position_y <= pixel_to_q(cmd.new_y);
                state      <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_FADE: begin
          if (!fade_active) begin
            state <= S_MOVE;
          end else if (fade_mode == MODE_IDLE) begin
            // no output change, timer parks just past the period
            if (fade_stay) fade_timer <= fade_adv;
            state <= S_MOVE;
          end else begin
            if (fade_expire) begin
              // wrap: timer restarts from zero and advances by this step
              fade_timer <= TIMER_W'(step_r);
              if (fade_mode == MODE_ONCE) fade_active <= 1'b0;
              if (fade_mode == MODE_PINGPONG) fade_rising <= !fade_rising;
            end else begin
              fade_timer <= fade_adv;
            end
            state <= S_FMUL;
          end
        end
        S_FMUL: state <= S_FDIV;
        S_FDIV: begin
          if (div_rsp.done) begin
            alpha_level <= alpha_c;
            state       <= S_MOVE;
          end
        end
        S_MOVE: begin
          if (!move_active) begin
            state <= S_DONE;
          end else if (move_mode == MODE_IDLE) begin
            if (move_stay) move_timer <= move_adv;
            state <= S_DONE;
          end else begin
            if (move_expire) begin
              move_timer <= TIMER_W'(step_r);
              if (move_mode == MODE_ONCE) move_active <= 1'b0;
              if (move_mode == MODE_LOOP) begin
                position_x <= pixel_to_q(cfg.start_point[PIX_W-1:0]);
                position_y <= pixel_to_q(cfg.start_point[POS_W-1:PIX_W]);
              end
              if (move_mode == MODE_PINGPONG) begin
                // leg flips; a forward leg restarts at start, a return leg at end
                move_forward <= !move_forward;
                if (move_forward) begin
                  position_x <= pixel_to_q(cfg.end_point[PIX_W-1:0]);
                  position_y <= pixel_to_q(cfg.end_point[POS_W-1:PIX_W]);
                end else begin
                  position_x <= pixel_to_q(cfg.start_point[PIX_W-1:0]);
                  position_y <= pixel_to_q(cfg.start_point[POS_W-1:PIX_W]);
                end
              end
            end else begin
              move_timer <= move_adv;
            end
            state <= S_XMUL;
          end
        end
        S_XMUL: state <= S_XDIV;
        S_XDIV: begin
          if (div_rsp.done) begin
            position_x <= x_sub ? position_x - div_rsp.quot : position_x + div_rsp.quot;
            state      <= S_YMUL;
          end
        end
        S_YMUL: state <= S_YDIV;
        S_YDIV: begin
          if (div_rsp.done) begin
            position_y <= y_sub ? position_y - div_rsp.quot : position_y + div_rsp.quot;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // operand capture, no reset needed
  always_ff @(posedge clk) begin
    if (cmd_fire) step_r <= cmd.step_time;
    if (state == S_FADE) begin
      fade_t_op <= fade_expire ? '0 : fade_timer;
      fade_neg  <= fade_d[ALPHA_W];
      fade_mag  <= fade_d[ALPHA_W] ? fade_d_n[ALPHA_W-1:0] : fade_d[ALPHA_W-1:0];
    end
    if (state == S_MOVE) begin
      neg_x <= dx[PIX_W];
      mag_x <= dx[PIX_W] ? dx_n[PIX_W-1:0] : dx[PIX_W-1:0];
      neg_y <= dy[PIX_W];
      mag_y <= dy[PIX_W] ? dy_n[PIX_W-1:0] : dy[PIX_W-1:0];
    end
  end

  // result register
  logic res_load;
  assign res_load = (state == S_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_alpha <= alpha_level;
      res_pos_x <= position_x[POS_W-1:PIX_W];
      res_pos_y <= position_y[POS_W-1:PIX_W];
      res_fade  <= fade_active;
      res_move  <= move_active;
    end
  end

  assign res.valid        = res_valid;
  assign res.alpha        = res_alpha;
  assign res.pos_x        = res_pos_x;
  assign res.pos_y        = res_pos_y;
  assign res.fade_running = res_fade;
  assign res.move_running = res_move;

`ifndef SYNTHESIS
  a_done_in_wait_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_FDIV || state == S_XDIV || state == S_YDIV))
    else $error("divider result arrived outside a wait state");

  a_ready_div_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !div_rsp.busy)
    else $error("input ready while a division is in flight");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> state != S_IDLE)
    else $error("accepted transaction produced no work");

  a_fade_stop_on_tick: assert property (@(posedge clk) disable iff (rst)
    $fell(fade_active) && !$past(rst) |-> $past(state == S_FADE))
    else $error("fade stopped outside the fade step");
`endif

endmodule

`default_nettype wire

@@ sv/ltfm_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ltfm_cfg_regs: apb register file holding the tween configuration
// depends on ltfm_pkg

module ltfm_cfg_regs
  import ltfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t       regs;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[APB_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode_control <= '0;
      regs.fade_period  <= PERIOD_RST;
      regs.alpha_start  <= '0;
      regs.alpha_end    <= ALPHA_END_RST;
      regs.move_period  <= PERIOD_RST;
      regs.start_point  <= '0;
      regs.end_point    <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_MODE_CONTROL: regs.mode_control <= pwdata[MODE_W-1:0];
        REG_FADE_PERIOD:  regs.fade_period  <= pwdata[PERIOD_W-1:0];
        REG_ALPHA_START:  regs.alpha_start  <= pwdata[ALPHA_W-1:0];
        REG_ALPHA_END:    regs.alpha_end    <= pwdata[ALPHA_W-1:0];
        REG_MOVE_PERIOD:  regs.move_period  <= pwdata[PERIOD_W-1:0];
        REG_START_POINT:  regs.start_point  <= pwdata[POS_W-1:0];
        REG_END_POINT:    regs.end_point    <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE_CONTROL: prdata = APB_DATA_W'(regs.mode_control);
      REG_FADE_PERIOD:  prdata = APB_DATA_W'(regs.fade_period);
      REG_ALPHA_START:  prdata = APB_DATA_W'(regs.alpha_start);
      REG_ALPHA_END:    prdata = APB_DATA_W'(regs.alpha_end);
      REG_MOVE_PERIOD:  prdata = APB_DATA_W'(regs.move_period);
      REG_START_POINT:  prdata = regs.start_point;
      REG_END_POINT:    prdata = regs.end_point;
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/ltfm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ltfm_div: shared restoring divider, 48-bit dividend by 24-bit divisor,
// two quotient bits per cycle, low 32 quotient bits kept; depends on ltfm_pkg

module ltfm_div
  import ltfm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PERIOD_W-1:0]  rem;
  logic [PERIOD_W-1:0]  den;
  logic [DIV_NUM_W-1:0] num;
  logic [DIV_Q_W-1:0]   quot;

  logic [PERIOD_W:0]    part1, part2;
  logic [PERIOD_W:0]    diff1, diff2;
  logic [PERIOD_W-1:0]  rem1, rem2;
  logic                 qb1, qb2;

  // two dependent compare-subtract steps
  always_comb begin
    part1 = {rem, num[DIV_NUM_W-1]};
    qb1   = part1 >= {1'b0, den};
    diff1 = part1 - {1'b0, den};
    rem1  = qb1 ? diff1[PERIOD_W-1:0] : part1[PERIOD_W-1:0];
    part2 = {rem1, num[DIV_NUM_W-2]};
    qb2   = part2 >= {1'b0, den};
    diff2 = part2 - {1'b0, den};
    rem2  = qb2 ? diff2[PERIOD_W-1:0] : part2[PERIOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      den <= req.den;
      num <= req.num;
    end else if (busy) begin
      rem  <= rem2;
      num  <= {num[DIV_NUM_W-3:0], 2'b00};
      quot <= {quot[DIV_Q_W-3:0], qb1, qb2};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

`ifndef SYNTHESIS
  a_no_start_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start)
    else $error("divider restarted while busy");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    req.start |-> req.den != '0)
    else $error("divider started with zero divisor");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < den)
    else $error("partial remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("done without a finished division");
`endif

endmodule

`default_nettype wire
